/* rtl/core/bur_pkg.sv */
// shared types, constants and generator functions for the bounded random generator
package bur_pkg;

    localparam logic [1:0] CMD_RAW   = 2'd0;
    localparam logic [1:0] CMD_BOUND = 2'd1;
    localparam logic [1:0] CMD_FRAC  = 2'd2;

    // job kinds handed from front to back
    localparam logic [1:0] K_RAW   = 2'd0;
    localparam logic [1:0] K_BOUND = 2'd1;
    localparam logic [1:0] K_FRAC  = 2'd2;
    localparam logic [1:0] K_CONST = 2'd3;

    localparam logic [31:0] MAT1      = 32'h8f7011ee;
    localparam logic [31:0] MAT2      = 32'hfc78ff1f;
    localparam logic [31:0] TMAT      = 32'h3793fdff;
    localparam logic [31:0] SH_MASK   = 32'h7fffffff;
    localparam logic [31:0] INIT_MULT = 32'd1812433253;

    localparam logic [2:0] SEED_STEPS = 3'd7;
    localparam logic [4:0] WARM_LAST  = 5'd7;
    localparam logic [4:0] DIV_LAST   = 5'd31;

    localparam logic [1:0] ADDR_SEED = 2'd0;

    typedef logic [3:0][31:0] t_gen;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] n;
        logic [31:0] lo;
    } t_job;

    typedef struct packed {
        logic [1:0] count;
    } t_front_stat;

    typedef struct packed {
        logic seeding;
        logic busy;
    } t_back_stat;

    // one step of the state recurrence
    function automatic t_gen gen_adv(input t_gen g);
        t_gen        r;
        logic [31:0] x;
        logic [31:0] y;
        y = g[3];
        x = (g[0] & SH_MASK) ^ g[1] ^ g[2];
        x = x ^ (x << 1);
        y = y ^ (y >> 1) ^ x;
        r[0] = g[1];
        r[1] = g[2];
        r[2] = x ^ (y << 10);
        r[3] = y;
        if (y[0]) begin
            r[1] = r[1] ^ MAT1;
            r[2] = r[2] ^ MAT2;
        end
        return r;
    endfunction

    // output tempering of an advanced state
    function automatic logic [31:0] gen_temper(input t_gen g);
        logic [31:0] t0;
        logic [31:0] t1;
        t1 = g[0] + (g[2] >> 8);
        t0 = g[3] ^ t1;
        if (t1[0]) begin
            t0 = t0 ^ TMAT;
        end
        return t0;
    endfunction

endpackage

/* rtl/core/bur_if.sv */
// request and result channel interfaces
interface bur_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [31:0] low_bound;
    logic [31:0] high_bound;
    modport source(output valid, cmd, low_bound, high_bound, input ready);
    modport sink(input valid, cmd, low_bound, high_bound, output ready);
endinterface

interface bur_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    modport source(output valid, value, input ready);
    modport sink(input valid, value, output ready);
endinterface

/* rtl/core/bur_front.sv */
// request front end: classifies items and queues jobs for the back end
module bur_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bur_req_if.sink               i_req,
    output bur_pkg::t_job         o_job,
    output logic                  o_job_valid,
    input  logic                  i_job_ready,
    output bur_pkg::t_front_stat  o_stat
);
    import bur_pkg::*;

    t_job        r_q [2];
    logic        r_wr;
    logic        r_rd;
    logic [1:0]  r_cnt;
    t_job        cls;
    logic [31:0] n;
    logic        push;
    logic        pop;

    // classify the incoming item
    always_comb begin
        n = i_req.high_bound - i_req.low_bound + 32'd1;
        cls.n = n;
        cls.lo = i_req.low_bound;
        case (i_req.cmd)
            CMD_RAW:  cls.kind = K_RAW;
            CMD_FRAC: cls.kind = K_FRAC;
            CMD_BOUND: begin
                if (i_req.high_bound <= i_req.low_bound || n == 32'd0) begin
                    cls.kind = K_CONST;
                end else begin
                    cls.kind = K_BOUND;
                end
            end
            default: begin
                cls.kind = K_CONST;
                cls.lo = 32'd0;
            end
        endcase
    end

    assign i_req.ready = (r_cnt != 2'd2);
    assign push = i_req.valid && i_req.ready;
    assign pop = o_job_valid && i_job_ready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job = r_q[r_rd];
    assign o_stat.count = r_cnt;

    // two-entry job queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= 1'b0;
            r_rd <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_q[r_wr] <= cls;
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

/* rtl/core/bur_back.sv */
// back end: generator state, seeding sequencer, serial remainder and result register
module bur_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_seed_we,
    input  logic [31:0]          i_seed_val,
    input  bur_pkg::t_job        i_job,
    input  logic                 i_job_valid,
    output logic                 o_job_ready,
    bur_rsp_if.source            o_rsp,
    output bur_pkg::t_back_stat  o_stat
);
    import bur_pkg::*;

    localparam logic [2:0] S_SEED_MUL = 3'd0;
    localparam logic [2:0] S_SEED_ACC = 3'd1;
    localparam logic [2:0] S_WARM     = 3'd2;
    localparam logic [2:0] S_IDLE     = 3'd3;
    localparam logic [2:0] S_THR      = 3'd4;
    localparam logic [2:0] S_DRAW     = 3'd5;
    localparam logic [2:0] S_MOD      = 3'd6;

    logic [2:0]  r_state;
    t_gen        r_g;
    logic [2:0]  r_i;
    logic [4:0]  r_cnt;
    logic [31:0] r_prod;
    logic [31:0] r_rem;
    logic [31:0] r_div;
    logic [31:0] r_n;
    logic [31:0] r_lo;
    logic [31:0] r_thr;
    logic        r_out_valid;
    logic [31:0] r_out_val;

    t_gen        g_adv;
    logic [31:0] word;
    logic [31:0] p;
    logic [31:0] prod;
    logic [32:0] trial;
    logic [31:0] rem_next;
    t_gen        g_seed;
    logic [1:0]  slot;
    logic        take;

    assign g_adv = gen_adv(r_g);
    assign word = gen_temper(g_adv);
    assign slot = r_i[1:0];
    assign p = r_g[slot - 2'd1];
    assign prod = INIT_MULT * (p ^ (p >> 30));

    // one restoring step of the shared remainder unit
    always_comb begin
        trial = {r_rem, r_div[31]};
        if (trial >= {1'b0, r_n}) begin
            trial = trial - {1'b0, r_n};
        end
        rem_next = trial[31:0];
    end

    // seeding accumulate with period certification
    always_comb begin
        g_seed = r_g;
        g_seed[slot] = r_g[slot] ^ ({29'd0, r_i} + r_prod);
        if (r_i == SEED_STEPS && (g_seed[0] & SH_MASK) == 32'd0 && g_seed[1] == 32'd0
            && g_seed[2] == 32'd0 && g_seed[3] == 32'd0) begin
            g_seed[0] = 32'h54;
            g_seed[1] = 32'h49;
            g_seed[2] = 32'h4e;
            g_seed[3] = 32'h59;
        end
    end

    assign o_job_ready = (r_state == S_IDLE) && !r_out_valid;
    assign take = i_job_valid && o_job_ready;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.value = r_out_val;
    assign o_stat.seeding = (r_state == S_SEED_MUL) || (r_state == S_SEED_ACC)
                            || (r_state == S_WARM);
    assign o_stat.busy = (r_state != S_IDLE);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SEED_MUL;
            r_g <= {TMAT, MAT2, MAT1, 32'd0};
            r_i <= 3'd1;
            r_cnt <= 5'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_rsp.valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_seed_we) begin
                r_state <= S_SEED_MUL;
                r_g <= {TMAT, MAT2, MAT1, i_seed_val};
                r_i <= 3'd1;
            end else begin
                case (r_state)
                    S_SEED_MUL: begin
                        r_prod <= prod;
                        r_state <= S_SEED_ACC;
                    end
                    S_SEED_ACC: begin
                        r_g <= g_seed;
                        r_i <= r_i + 3'd1;
                        r_cnt <= 5'd0;
                        r_state <= (r_i == SEED_STEPS) ? S_WARM : S_SEED_MUL;
                    end
                    S_WARM: begin
                        r_g <= g_adv;
                        r_cnt <= r_cnt + 5'd1;
                        if (r_cnt == WARM_LAST) begin
                            r_state <= S_IDLE;
                        end
                    end
                    S_IDLE: begin
                        if (take) begin
                            r_n <= i_job.n;
                            r_lo <= i_job.lo;
                            case (i_job.kind)
                                K_RAW: begin
                                    r_g <= g_adv;
                                    r_out_val <= word;
                                    r_out_valid <= 1'b1;
                                end
                                K_FRAC: begin
                                    r_g <= g_adv;
                                    r_out_val <= word >> 8;
                                    r_out_valid <= 1'b1;
                                end
                                K_BOUND: begin
                                    r_rem <= 32'd0;
                                    r_div <= 32'd0 - i_job.n;
                                    r_cnt <= 5'd0;
                                    r_state <= S_THR;
                                end
                                default: begin
                                    r_out_val <= i_job.lo;
                                    r_out_valid <= 1'b1;
                                end
                            endcase
                        end
                    end
                    S_THR: begin
                        r_rem <= rem_next;
                        r_div <= r_div << 1;
                        r_cnt <= r_cnt + 5'd1;
                        if (r_cnt == DIV_LAST) begin
                            r_thr <= rem_next;
                            r_state <= S_DRAW;
                        end
                    end
                    S_DRAW: begin
                        r_g <= g_adv;
                        if (word >= r_thr) begin
                            r_rem <= 32'd0;
                            r_div <= word;
                            r_cnt <= 5'd0;
                            r_state <= S_MOD;
                        end
                    end
                    S_MOD: begin
                        r_rem <= rem_next;
                        r_div <= r_div << 1;
                        r_cnt <= r_cnt + 5'd1;
                        if (r_cnt == DIV_LAST) begin
                            r_out_val <= r_lo + rem_next;
                            r_out_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

endmodule

/* rtl/core/bounded_uniform_random_generator.sv */
// Bounded uniform random generator: one 32-bit result per request, either a raw tempered
// word, an unbiased draw in [low_bound, high_bound] or a 24-bit fraction. A bounded draw
// uses the bit-serial remainder unit first to compute the rejection threshold, then draws
// words until one is not below the threshold, and then reduces that word modulo the span.
// Empty, reversed or full ranges and unused commands answer without a draw. After reset and
// after each seed write the generator reseeds (seven multiply-accumulate steps, each a
// multiply state then an accumulate state, and eight warm-up steps) and the back end
// takes no job meanwhile. A two-entry queue between front and back decouples them.
module bounded_uniform_random_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bur_req_if.sink     i_req,
    bur_rsp_if.source   o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bur_pkg::*;

    logic        r_seed;
    logic [31:0] r_seed_val;
    logic        seed_we;
    t_job        job;
    logic        job_valid;
    logic        job_ready;
    t_front_stat fstat;
    t_back_stat  bstat;

    // configuration port
    assign pready = 1'b1;
    assign seed_we = psel && penable && pwrite && ({1'b0, paddr[2]} == ADDR_SEED);
    assign prdata = r_seed_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_val <= 32'd0;
            r_seed <= 1'b0;
        end else begin
            r_seed <= seed_we;
            if (seed_we) begin
                r_seed_val <= pwdata;
            end
        end
    end

    bur_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_job       (job),
        .o_job_valid (job_valid),
        .i_job_ready (job_ready),
        .o_stat      (fstat)
    );

    bur_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seed_we   (seed_we),
        .i_seed_val  (pwdata),
        .i_job       (job),
        .i_job_valid (job_valid),
        .o_job_ready (job_ready),
        .o_rsp       (o_rsp),
        .o_stat      (bstat)
    );

    // checks
    a_seed_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seed |-> bstat.seeding)
        else $error("seed write did not restart seeding");
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fstat.count != 2'd3)
        else $error("job queue overflow");
    a_back_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (job_valid && job_ready && !seed_we) |=> !job_ready)
        else $error("back end took a second job while busy");
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (job_valid && job_ready) |-> !bstat.busy)
        else $error("back end took a job while not idle");

endmodule

/* tb/tb_bounded_uniform_random_generator.sv */
// testbench for the bounded uniform random generator: predicted draws checked item by item
module tb_bounded_uniform_random_generator;
    import bur_pkg::*;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] lo;
        logic [31:0] hi;
    } t_request;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bur_req_if req_if();
    bur_rsp_if rsp_if();

    bounded_uniform_random_generator u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    logic [3:0][31:0] mt_state;
    logic [31:0]      expected_values[$];
    t_request         pending_requests[$];
    int               error_count;
    int               cycle_count;
    int               sent_count;
    int               received_count;
    int               hold_off_cycles;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 900000) begin
            $display("tb_bounded_uniform_random_generator: errors");
            $finish;
        end
    end

    // one step of the tiny twister recurrence
    function automatic logic [3:0][31:0] mt_next(input logic [3:0][31:0] s);
        logic [3:0][31:0] r;
        logic [31:0]      x;
        logic [31:0]      y;
        y = s[3];
        x = (s[0] & 32'h7fffffff) ^ s[1] ^ s[2];
        x = x ^ (x << 1);
        y = y ^ (y >> 1) ^ x;
        r[0] = s[1];
        r[1] = s[2];
        r[2] = x ^ (y << 10);
        r[3] = y;
        if (y[0]) begin
            r[1] = r[1] ^ MAT1;
            r[2] = r[2] ^ MAT2;
        end
        return r;
    endfunction

    // advance and temper one word
    function automatic logic [31:0] mt_draw();
        logic [31:0] t0;
        logic [31:0] t1;
        mt_state = mt_next(mt_state);
        t1 = mt_state[0] + (mt_state[2] >> 8);
        t0 = mt_state[3] ^ t1;
        if (t1[0]) t0 = t0 ^ TMAT;
        return t0;
    endfunction

    // initialization from a seed
    function automatic void mt_seed(input logic [31:0] s);
        logic [31:0] p;
        mt_state[0] = s;
        mt_state[1] = MAT1;
        mt_state[2] = MAT2;
        mt_state[3] = TMAT;
        for (int i = 1; i < 8; i++) begin
            p = mt_state[(i - 1) & 3];
            mt_state[i & 3] = mt_state[i & 3] ^ (32'(i) + INIT_MULT * (p ^ (p >> 30)));
        end
        // degenerate state replaced by fixed words
        if ((mt_state[0] & 32'h7fffffff) == 0 && mt_state[1] == 0 && mt_state[2] == 0
            && mt_state[3] == 0) begin
            mt_state[0] = 32'h54;
            mt_state[1] = 32'h49;
            mt_state[2] = 32'h4e;
            mt_state[3] = 32'h59;
        end
        for (int i = 0; i < 8; i++) mt_state = mt_next(mt_state);
    endfunction

    // expected value of one request
    function automatic logic [31:0] predict_value(input t_request q);
        logic [31:0] n;
        logic [31:0] floor_limit;
        logic [31:0] w;
        case (q.cmd)
            CMD_RAW: return mt_draw();
            CMD_FRAC: return mt_draw() >> 8;
            CMD_BOUND: begin
                if (q.hi <= q.lo) return q.lo;
                n = q.hi - q.lo + 32'd1;
                if (n < 2) return q.lo;
                floor_limit = (32'd0 - n) % n;
                do w = mt_draw(); while (w < floor_limit);
                return q.lo + w % n;
            end
            default: return 32'd0;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    // flag sampled at the rising edge so the driver sees the accept
    logic req_accepted;
    always @(posedge i_clk) req_accepted <= req_if.valid && req_if.ready;

    // driver: offers pending items with random gaps
    int gap_left;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            gap_left <= 0;
        end else if (req_if.valid && !req_accepted) begin
            // hold until accepted
        end else begin
            if (req_accepted) begin
                expected_values.push_back(predict_value(pending_requests.pop_front()));
                sent_count++;
            end
            if (gap_left > 0 || pending_requests.size() == 0) begin
                req_if.valid <= 1'b0;
                if (gap_left > 0) gap_left <= gap_left - 1;
            end else begin
                req_if.valid      <= 1'b1;
                req_if.cmd        <= pending_requests[0].cmd;
                req_if.low_bound  <= pending_requests[0].lo;
                req_if.high_bound <= pending_requests[0].hi;
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            end
        end
    end

    // receiver ready with random stalls and one long hold-off
    int stall_left;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            stall_left   <= 0;
        end else if (hold_off_cycles > 0) begin
            rsp_if.ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (rsp_if.ready && rsp_if.valid) begin
            stall_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    // monitor: checks each accepted result against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            received_count++;
            if (expected_values.size() == 0)
                report_mismatch("unexpected result", rsp_if.value, 32'd0);
            else if (rsp_if.value !== expected_values[0])
                report_mismatch("value", rsp_if.value, expected_values.pop_front());
            else
                void'(expected_values.pop_front());
        end
    end

    task automatic write_seed(input logic [31:0] s);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'({ADDR_SEED, 2'b00});
        pwdata  <= s;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        mt_seed(s);
    endtask

    task automatic add_request(input logic [1:0] c, input logic [31:0] l,
                               input logic [31:0] h);
        t_request q;
        q.cmd = c;
        q.lo  = l;
        q.hi  = h;
        pending_requests.push_back(q);
    endtask

    // random bound with a bias toward edges
    function automatic logic [31:0] rand_bound();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 20);
            1: return 32'hffffffff - $urandom_range(0, 20);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_random_batch(input int count);
        logic [31:0] l;
        logic [31:0] h;
        for (int i = 0; i < count; i++) begin
            l = rand_bound();
            case ($urandom_range(0, 9))
                0: h = l + $urandom_range(0, 16);
                1: h = rand_bound();
                2: h = l - $urandom_range(0, 3);
                3: h = l + (32'h1 << $urandom_range(0, 31)) - 1;
                4: h = l + $urandom_range(0, 2000);
                default: h = l | $urandom;
            endcase
            add_request(($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2)), l, h);
        end
    endtask

    task automatic drain();
        while (pending_requests.size() > 0 || req_if.valid || expected_values.size() > 0
               || sent_count != received_count)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    // stimulus
    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_if.valid = 1'b0;
        req_if.cmd = CMD_RAW;
        req_if.low_bound = '0;
        req_if.high_bound = '0;
        rsp_if.ready = 1'b0;
        error_count = 0;
        cycle_count = 0;
        sent_count = 0;
        received_count = 0;
        hold_off_cycles = 0;
        mt_seed(32'd0);
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: every command, range edges, full range, unused command
        add_request(CMD_RAW, 32'd0, 32'd0);
        add_request(CMD_FRAC, 32'hffffffff, 32'hffffffff);
        add_request(CMD_BOUND, 32'd5, 32'd5);
        add_request(CMD_BOUND, 32'd9, 32'd3);
        add_request(CMD_BOUND, 32'd0, 32'hffffffff);
        add_request(CMD_BOUND, 32'd0, 32'd1);
        add_request(CMD_BOUND, 32'd0, 32'hfffffffe);
        add_request(CMD_BOUND, 32'd1, 32'hffffffff);
        add_request(CMD_BOUND, 32'hfffffffe, 32'hffffffff);
        add_request(CMD_BOUND, 32'd0, 32'h80000000);
        add_request(CMD_BOUND, 32'd100, 32'd102);
        add_request(2'd3, 32'hffffffff, 32'hffffffff);
        add_request(CMD_RAW, 32'hffffffff, 32'd0);
        add_request(CMD_FRAC, 32'd0, 32'd0);
        drain();

        // seed settings including extremes
        write_seed(32'hffffffff);
        add_random_batch(300);
        drain();
        write_seed(32'd0);
        add_random_batch(300);
        drain();
        write_seed($urandom);
        add_random_batch(250);
        // long receiver hold-off while the sender keeps offering
        wait (sent_count > 30);
        hold_off_cycles = 400;
        drain();
        write_seed(32'h80000000);
        add_random_batch(400);
        drain();
        write_seed($urandom);
        add_random_batch(400);
        drain();

        if (error_count == 0 && expected_values.size() == 0)
            $display("tb_bounded_uniform_random_generator: clean");
        else
            $display("tb_bounded_uniform_random_generator: errors");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/bur_pkg.sv
rtl/core/bur_if.sv
rtl/core/bur_front.sv
rtl/core/bur_back.sv
rtl/core/bounded_uniform_random_generator.sv
tb/tb_bounded_uniform_random_generator.sv
